@@ sv/rls_inertia_damping_estimator_macros.svh @@
// ----------------------------------------------------------------------------
// RLS estimator assertion macros
// Shorthand for the concurrent checks used in the estimator modules.
// ----------------------------------------------------------------------------
`ifndef RLS_INERTIA_DAMPING_ESTIMATOR_MACROS_SVH
`define RLS_INERTIA_DAMPING_ESTIMATOR_MACROS_SVH

// Same-cycle implication, clocked on clk, off while in reset
`define RIE_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, clocked on clk, off while in reset
`define RIE_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ sv/rie_pkg.sv @@
// ----------------------------------------------------------------------------
// RLS estimator package
// Beat types, operand and opcode codes, register file map and the microcode.
// ----------------------------------------------------------------------------
package rie_pkg;

  localparam int FRACTION_BITS_DEF = 32;

  // Configuration register indexes
  localparam logic [1:0] CFG_PERIOD   = 2'd0;
  localparam logic [1:0] CFG_INERTIA  = 2'd1;
  localparam logic [1:0] CFG_COV      = 2'd2;
  localparam logic [1:0] CFG_FORGET   = 2'd3;

  localparam logic [19:0] PERIOD_RST  = 20'd62500;
  localparam logic [15:0] INERTIA_RST = 16'd28;
  localparam logic [15:0] COV_RST     = 16'd1000;
  localparam logic [24:0] FORGET_RST  = 25'd32767;

  typedef struct packed {
    logic               kind;
    logic signed [31:0] speed_sample;
    logic signed [31:0] torque_sample;
  } in_beat_t;

  typedef struct packed {
    logic signed [63:0] inertia_estimate;
    logic signed [63:0] damping_estimate;
    logic signed [63:0] prediction_error;
    logic               saturated;
  } out_beat_t;

  // Multiply/divide modes: general divide, or divide by a power of two
  typedef enum logic [1:0] {MD_DIV, MD_SHF, MD_SH24, MD_SH0} md_mode_t;

  typedef struct packed {
    logic signed [63:0] a;
    logic signed [63:0] b;
    logic signed [63:0] d;
    md_mode_t           mode;
  } mdu_req_t;

  typedef struct packed {
    logic               busy;
    logic               done;
    logic signed [63:0] q;
    logic               sat;
  } mdu_rsp_t;

  typedef enum logic [1:0] {OP_ADD, OP_SUB, OP_MD, OP_END} op_t;

  typedef enum logic [3:0] {
    S_PA, S_PB, S_ZERO, S_FX, S_NEGFX, S_K1000, S_PERIOD, S_INERTIA,
    S_COV0, S_CODE, S_SPEED, S_TORQUE
  } src_t;

  // Register file map
  localparam int RF_DEPTH = 24;
  localparam logic [4:0] R_LS    = 5'd0;
  localparam logic [4:0] R_LT    = 5'd1;
  localparam logic [4:0] R_CS    = 5'd2;
  localparam logic [4:0] R_CT    = 5'd3;
  localparam logic [4:0] R_G0    = 5'd4;
  localparam logic [4:0] R_G1    = 5'd5;
  localparam logic [4:0] R_P00   = 5'd6;
  localparam logic [4:0] R_P01   = 5'd7;
  localparam logic [4:0] R_P10   = 5'd8;
  localparam logic [4:0] R_P11   = 5'd9;
  localparam logic [4:0] R_PS0   = 5'd10;
  localparam logic [4:0] R_X     = 5'd11;
  localparam logic [4:0] R_Y     = 5'd12;
  localparam logic [4:0] R_PRED  = 5'd13;
  localparam logic [4:0] R_ERR   = 5'd14;
  localparam logic [4:0] R_PS1   = 5'd15;
  localparam logic [4:0] R_I1    = 5'd16;
  localparam logic [4:0] R_I2    = 5'd17;
  localparam logic [4:0] R_J     = 5'd18;
  localparam logic [4:0] R_LAM   = 5'd19;
  localparam logic [4:0] R_DEN   = 5'd20;
  localparam logic [4:0] R_RATIO = 5'd21;
  localparam logic [4:0] R_INR   = 5'd22;
  localparam logic [4:0] R_DMP   = 5'd23;

  localparam logic [5:0] PC_SAMPLE  = 6'd0;
  localparam logic [5:0] PC_RESTART = 6'd43;

  typedef struct packed {
    op_t        op;
    logic [4:0] dst;
    logic [4:0] ra;
    logic [4:0] rb;
    src_t       sa;
    src_t       sb;
    src_t       sd;
    md_mode_t   mode;
  } uc_t;

  function automatic uc_t mk(op_t op, logic [4:0] dst, logic [4:0] ra, logic [4:0] rb,
                             src_t sa, src_t sb, src_t sd, md_mode_t mode);
    uc_t u;
    u.op = op; u.dst = dst; u.ra = ra; u.rb = rb;
    u.sa = sa; u.sb = sb; u.sd = sd; u.mode = mode;
    return u;
  endfunction

  // Microcode: sample sequence, then restart sequence
  function automatic uc_t uc_rom(logic [5:0] pc);
    uc_t u;
    unique case (pc)
      // prediction from previous speed and torque
      6'd0:  u = mk(OP_SUB, R_PS0, R_LS, R_LS, S_ZERO, S_PB, S_ZERO, MD_SH0);
      6'd1:  u = mk(OP_MD,  R_X, R_PS0, R_CS, S_PA, S_PB, S_ZERO, MD_SHF);
      6'd2:  u = mk(OP_MD,  R_Y, R_LT, R_CT, S_PA, S_PB, S_ZERO, MD_SHF);
      6'd3:  u = mk(OP_ADD, R_PRED, R_X, R_Y, S_PA, S_PB, S_ZERO, MD_SH0);
      6'd4:  u = mk(OP_MD,  R_LS, R_LS, R_LS, S_SPEED, S_FX, S_ZERO, MD_SH0);
      6'd5:  u = mk(OP_MD,  R_LT, R_LT, R_LT, S_TORQUE, S_FX, S_ZERO, MD_SH0);
      6'd6:  u = mk(OP_SUB, R_ERR, R_LS, R_PRED, S_PA, S_PB, S_ZERO, MD_SH0);
      // coefficient update with previous gain
      6'd7:  u = mk(OP_MD,  R_X, R_G0, R_ERR, S_PA, S_PB, S_ZERO, MD_SHF);
      6'd8:  u = mk(OP_ADD, R_CS, R_CS, R_X, S_PA, S_PB, S_ZERO, MD_SH0);
      6'd9:  u = mk(OP_MD,  R_X, R_G1, R_ERR, S_PA, S_PB, S_ZERO, MD_SHF);
      6'd10: u = mk(OP_ADD, R_CT, R_CT, R_X, S_PA, S_PB, S_ZERO, MD_SH0);
      // P * phi
      6'd11: u = mk(OP_SUB, R_PS1, R_LS, R_LS, S_ZERO, S_PB, S_ZERO, MD_SH0);
      6'd12: u = mk(OP_MD,  R_X, R_P00, R_PS1, S_PA, S_PB, S_ZERO, MD_SHF);
      6'd13: u = mk(OP_MD,  R_Y, R_P01, R_LT, S_PA, S_PB, S_ZERO, MD_SHF);
      6'd14: u = mk(OP_ADD, R_I1, R_X, R_Y, S_PA, S_PB, S_ZERO, MD_SH0);
      6'd15: u = mk(OP_MD,  R_X, R_P10, R_PS1, S_PA, S_PB, S_ZERO, MD_SHF);
      6'd16: u = mk(OP_MD,  R_Y, R_P11, R_LT, S_PA, S_PB, S_ZERO, MD_SHF);
      6'd17: u = mk(OP_ADD, R_I2, R_X, R_Y, S_PA, S_PB, S_ZERO, MD_SH0);
      6'd18: u = mk(OP_MD,  R_X, R_PS1, R_I1, S_PA, S_PB, S_ZERO, MD_SHF);
      6'd19: u = mk(OP_MD,  R_Y, R_LT, R_I2, S_PA, S_PB, S_ZERO, MD_SHF);
      6'd20: u = mk(OP_ADD, R_J, R_X, R_Y, S_PA, S_PB, S_ZERO, MD_SH0);
      // forgetting factor and gain
      6'd21: u = mk(OP_MD,  R_LAM, R_LAM, R_LAM, S_CODE, S_FX, S_ZERO, MD_SH24);
      6'd22: u = mk(OP_ADD, R_DEN, R_J, R_LAM, S_PA, S_PB, S_ZERO, MD_SH0);
      6'd23: u = mk(OP_MD,  R_G0, R_I1, R_DEN, S_PA, S_FX, S_PB, MD_DIV);
      6'd24: u = mk(OP_MD,  R_G1, R_I2, R_DEN, S_PA, S_FX, S_PB, MD_DIV);
      // covariance update, in place
      6'd25: u = mk(OP_MD,  R_X, R_G0, R_I1, S_PA, S_PB, S_ZERO, MD_SHF);
      6'd26: u = mk(OP_SUB, R_X, R_P00, R_X, S_PA, S_PB, S_ZERO, MD_SH0);
      6'd27: u = mk(OP_MD,  R_P00, R_X, R_LAM, S_PA, S_FX, S_PB, MD_DIV);
      6'd28: u = mk(OP_MD,  R_X, R_G0, R_I2, S_PA, S_PB, S_ZERO, MD_SHF);
      6'd29: u = mk(OP_SUB, R_X, R_P01, R_X, S_PA, S_PB, S_ZERO, MD_SH0);
      6'd30: u = mk(OP_MD,  R_P01, R_X, R_LAM, S_PA, S_FX, S_PB, MD_DIV);
      6'd31: u = mk(OP_MD,  R_X, R_G1, R_I1, S_PA, S_PB, S_ZERO, MD_SHF);
      6'd32: u = mk(OP_SUB, R_X, R_P10, R_X, S_PA, S_PB, S_ZERO, MD_SH0);
      6'd33: u = mk(OP_MD,  R_P10, R_X, R_LAM, S_PA, S_FX, S_PB, MD_DIV);
      6'd34: u = mk(OP_MD,  R_X, R_G1, R_I2, S_PA, S_PB, S_ZERO, MD_SHF);
      6'd35: u = mk(OP_SUB, R_X, R_P11, R_X, S_PA, S_PB, S_ZERO, MD_SH0);
      6'd36: u = mk(OP_MD,  R_P11, R_X, R_LAM, S_PA, S_FX, S_PB, MD_DIV);
      // inertia and damping
      6'd37: u = mk(OP_MD,  R_RATIO, R_CS, R_CT, S_PA, S_FX, S_PB, MD_DIV);
      6'd38: u = mk(OP_MD,  R_X, R_RATIO, R_RATIO, S_PA, S_PERIOD, S_K1000, MD_DIV);
      6'd39: u = mk(OP_SUB, R_INR, R_X, R_X, S_ZERO, S_PB, S_ZERO, MD_SH0);
      6'd40: u = mk(OP_ADD, R_X, R_CS, R_CS, S_PA, S_FX, S_ZERO, MD_SH0);
      6'd41: u = mk(OP_MD,  R_DMP, R_X, R_CT, S_PA, S_FX, S_PB, MD_DIV);
      6'd42: u = mk(OP_END, R_X, R_X, R_X, S_ZERO, S_ZERO, S_ZERO, MD_SH0);
      // restart: reload state from configuration
      6'd43: u = mk(OP_ADD, R_LS, R_X, R_X, S_ZERO, S_ZERO, S_ZERO, MD_SH0);
      6'd44: u = mk(OP_ADD, R_LT, R_X, R_X, S_ZERO, S_ZERO, S_ZERO, MD_SH0);
      6'd45: u = mk(OP_ADD, R_CS, R_X, R_X, S_NEGFX, S_ZERO, S_ZERO, MD_SH0);
      6'd46: u = mk(OP_MD,  R_X, R_X, R_X, S_INERTIA, S_K1000, S_ZERO, MD_SH0);
      6'd47: u = mk(OP_MD,  R_CT, R_X, R_X, S_PERIOD, S_FX, S_PB, MD_DIV);
      6'd48: u = mk(OP_ADD, R_G0, R_X, R_X, S_ZERO, S_ZERO, S_ZERO, MD_SH0);
      6'd49: u = mk(OP_ADD, R_G1, R_X, R_X, S_ZERO, S_ZERO, S_ZERO, MD_SH0);
      6'd50: u = mk(OP_MD,  R_P00, R_X, R_X, S_COV0, S_FX, S_ZERO, MD_SH0);
      6'd51: u = mk(OP_ADD, R_P01, R_X, R_X, S_ZERO, S_ZERO, S_ZERO, MD_SH0);
      6'd52: u = mk(OP_ADD, R_P10, R_X, R_X, S_ZERO, S_ZERO, S_ZERO, MD_SH0);
      6'd53: u = mk(OP_ADD, R_P11, R_P00, R_X, S_PA, S_ZERO, S_ZERO, MD_SH0);
      default: u = mk(OP_END, R_X, R_X, R_X, S_ZERO, S_ZERO, S_ZERO, MD_SH0);
    endcase
    return u;
  endfunction

endpackage

@@ sv/rie_mdu.sv @@
// ----------------------------------------------------------------------------
// RLS estimator multiply/divide unit
// round(a*b/d) or round(a*b/2^k), signed 64-bit, saturated, ties away from 0.
// ----------------------------------------------------------------------------
`include "rls_inertia_damping_estimator_macros.svh"

module rie_mdu #(
  parameter int FRACTION_BITS = rie_pkg::FRACTION_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  rie_pkg::mdu_req_t req,
  output rie_pkg::mdu_rsp_t rsp
);
  import rie_pkg::*;

  typedef enum logic [2:0] {M_IDLE, M_MUL, M_POST, M_DIV, M_RND, M_FIN} mst_t;

  localparam logic [63:0] MIN_V = 64'h8000_0000_0000_0000;
  localparam logic [63:0] MAX_V = 64'h7FFF_FFFF_FFFF_FFFF;

  mst_t           st_r;
  logic [63:0]    amag_r, bmag_r, dmag_r;
  logic           neg_r;
  md_mode_t       mode_r;
  logic [127:0]   acc_r;
  logic [63:0]    rem_r;
  logic [6:0]     cnt_r;
  logic [1:0]     k_r;
  logic           rnd_r;
  logic [63:0]    q_r;
  logic           sat_r;
  logic           done_r;

  function automatic logic [63:0] mag(logic [63:0] v);
    return v[63] ? (~v + 64'd1) : v;
  endfunction

  // Partial product, one 32x32 slice a cycle
  logic [31:0]  a_half, b_half;
  logic [63:0]  prod;
  logic [127:0] prod_sh;
  always_comb begin
    a_half = k_r[1] ? amag_r[63:32] : amag_r[31:0];
    b_half = k_r[0] ? bmag_r[63:32] : bmag_r[31:0];
    prod   = a_half * b_half;
    unique case (k_r)
      2'd0:    prod_sh = {64'd0, prod};
      2'd3:    prod_sh = {prod, 64'd0};
      default: prod_sh = {32'd0, prod, 32'd0};
    endcase
  end

  // Power-of-two scaling with its rounding bit
  logic [127:0] shq;
  logic         shr;
  always_comb begin
    unique case (mode_r)
      MD_SHF:  begin shq = acc_r >> FRACTION_BITS; shr = acc_r[FRACTION_BITS-1]; end
      MD_SH24: begin shq = acc_r >> 24;            shr = acc_r[23];              end
      default: begin shq = acc_r;                  shr = 1'b0;                   end
    endcase
  end

  // Restoring division step, one quotient bit a cycle
  logic [64:0] remsh;
  logic        ge;
  logic [63:0] rem_new;
  logic        rnd_new;
  always_comb begin
    remsh   = {rem_r, acc_r[127]};
    ge      = remsh >= {1'b0, dmag_r};
    rem_new = ge ? 64'(remsh - {1'b0, dmag_r}) : remsh[63:0];
    rnd_new = {rem_new, 1'b0} >= {1'b0, dmag_r};
  end

  // Final sign and saturation
  logic [63:0] pk_q;
  logic        pk_sat;
  always_comb begin
    if (neg_r) begin
      if ((|acc_r[127:64]) || (acc_r[63:0] > MIN_V)) begin
        pk_q = MIN_V; pk_sat = 1'b1;
      end else begin
        pk_q = 64'd0 - acc_r[63:0]; pk_sat = 1'b0;
      end
    end else begin
      if ((|acc_r[127:64]) || acc_r[63]) begin
        pk_q = MAX_V; pk_sat = 1'b1;
      end else begin
        pk_q = acc_r[63:0]; pk_sat = 1'b0;
      end
    end
  end

  // Sequencer; done is raised only on the way back to idle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= M_IDLE;
      done_r <= 1'b0;
      sat_r  <= 1'b0;
    end else begin
      unique case (st_r)
        M_IDLE: begin
          done_r <= 1'b0;
          if (start) begin
            amag_r <= mag(req.a);
            bmag_r <= mag(req.b);
            dmag_r <= mag(req.d);
            neg_r  <= req.a[63] ^ req.b[63] ^ ((req.mode == MD_DIV) && req.d[63]);
            mode_r <= req.mode;
            acc_r  <= '0;
            k_r    <= 2'd0;
            st_r   <= M_MUL;
          end
        end
        M_MUL: begin
          acc_r <= acc_r + prod_sh;
          k_r   <= k_r + 2'd1;
          if (k_r == 2'd3) st_r <= M_POST;
        end
        M_POST: begin
          if (mode_r == MD_DIV) begin
            if (dmag_r == 64'd0) begin
              q_r    <= neg_r ? MIN_V : MAX_V;
              sat_r  <= 1'b1;
              done_r <= 1'b1;
              st_r   <= M_IDLE;
            end else begin
              rem_r <= '0;
              cnt_r <= 7'd127;
              st_r  <= M_DIV;
            end
          end else begin
            acc_r <= shq;
            rnd_r <= shr;
            st_r  <= M_RND;
          end
        end
        M_DIV: begin
          rem_r <= rem_new;
          acc_r <= {acc_r[126:0], ge};
          cnt_r <= cnt_r - 7'd1;
          if (cnt_r == 7'd0) begin
            rnd_r <= rnd_new;
            st_r  <= M_RND;
          end
        end
        M_RND: begin
          acc_r <= acc_r + {127'd0, rnd_r};
          st_r  <= M_FIN;
        end
        M_FIN: begin
          q_r    <= pk_q;
          sat_r  <= pk_sat;
          done_r <= 1'b1;
          st_r   <= M_IDLE;
        end
        default: st_r <= M_IDLE;
      endcase
    end
  end

  assign rsp.busy = (st_r != M_IDLE);
  assign rsp.done = done_r;
  assign rsp.q    = q_r;
  assign rsp.sat  = sat_r;

  `RIE_ASSERT_IMP(a_start_idle, start, st_r == M_IDLE, "mdu started while busy")
  `RIE_ASSERT_NXT(a_done_pulse, done_r, !done_r, "mdu done longer than one cycle")
  `RIE_ASSERT_NXT(a_div_zero, (st_r == M_POST) && (mode_r == MD_DIV) && (dmag_r == 64'd0),
    done_r && sat_r, "zero divisor not flagged")

endmodule

@@ sv/rls_inertia_damping_estimator.sv @@
// ----------------------------------------------------------------------------
// RLS inertia and damping estimator
// Two-parameter recursive least squares with forgetting, fixed point.
// ----------------------------------------------------------------------------
// One beat in gives one beat out. A microcoded sequencer drives a single
// shared multiply/divide unit and a saturating adder over a 24-entry register
// file. A divide step yields one quotient bit per cycle over a 128-bit
// numerator. A sample beat runs 9 divides, 17 multiplies and 16 adds. The
// input stalls while a beat is in work; a finished result sits in the output
// register while the next beat is taken. After reset the restart sequence
// runs once before the first beat.
// ----------------------------------------------------------------------------
`include "rls_inertia_damping_estimator_macros.svh"

module rls_inertia_damping_estimator #(
  parameter int FRACTION_BITS = rie_pkg::FRACTION_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  rie_pkg::in_beat_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output rie_pkg::out_beat_t out_data,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [24:0]        cfg_wdata
);
  import rie_pkg::*;

  typedef enum logic [2:0] {S_IDLE, S_FETCH, S_EXEC, S_WAIT, S_DONE} st_t;

  localparam logic signed [63:0] FX    = 64'sd1 <<< FRACTION_BITS;
  localparam logic signed [63:0] MIN_V = 64'sh8000_0000_0000_0000;
  localparam logic signed [63:0] MAX_V = 64'sh7FFF_FFFF_FFFF_FFFF;

  st_t                st_r;
  logic [5:0]         pc_r;
  logic               boot_r;
  logic signed [31:0] speed_r, torque_r;
  logic               sat_r;
  logic signed [63:0] err_r, inr_r, dmp_r;
  logic               out_valid_r;
  out_beat_t          out_data_r;
  logic [19:0]        period_r;
  logic [15:0]        inertia_r, cov_r;
  logic [24:0]        code_r;

  logic signed [63:0] rf_mem [RF_DEPTH];
  logic signed [63:0] rda_r, rdb_r;

  uc_t      uc;
  mdu_req_t mdu_req;
  mdu_rsp_t mdu_rsp;
  logic     mdu_start;

  assign uc = uc_rom(pc_r);

  function automatic logic signed [63:0] opnd(src_t s);
    logic signed [63:0] v;
    unique case (s)
      S_PA:      v = rda_r;
      S_PB:      v = rdb_r;
      S_ZERO:    v = '0;
      S_FX:      v = FX;
      S_NEGFX:   v = -FX;
      S_K1000:   v = 64'sd1000;
      S_PERIOD:  v = {44'd0, period_r};
      S_INERTIA: v = {48'd0, inertia_r};
      S_COV0:    v = {48'd0, cov_r};
      S_CODE:    v = {39'd0, code_r};
      S_SPEED:   v = {{32{speed_r[31]}}, speed_r};
      S_TORQUE:  v = {{32{torque_r[31]}}, torque_r};
      default:   v = '0;
    endcase
    return v;
  endfunction

  // Operand selection and saturating add/subtract
  logic signed [63:0] opa, opb, opd;
  logic signed [64:0] sum65;
  logic signed [63:0] alu_q;
  logic               alu_sat;
  always_comb begin
    opa   = opnd(uc.sa);
    opb   = opnd(uc.sb);
    opd   = opnd(uc.sd);
    sum65 = (uc.op == OP_SUB) ? ({opa[63], opa} - {opb[63], opb})
                              : ({opa[63], opa} + {opb[63], opb});
    if (sum65[64] != sum65[63]) begin
      alu_q   = sum65[64] ? MIN_V : MAX_V;
      alu_sat = 1'b1;
    end else begin
      alu_q   = sum65[63:0];
      alu_sat = 1'b0;
    end
  end

  // Write-back
  logic               wb_en;
  logic signed [63:0] wb_data;
  logic               is_alu;
  always_comb begin
    is_alu  = (uc.op == OP_ADD) || (uc.op == OP_SUB);
    wb_en   = ((st_r == S_EXEC) && is_alu) || ((st_r == S_WAIT) && mdu_rsp.done);
    wb_data = (st_r == S_WAIT) ? mdu_rsp.q : alu_q;
  end

  assign mdu_start    = (st_r == S_EXEC) && (uc.op == OP_MD);
  assign mdu_req.a    = opa;
  assign mdu_req.b    = opb;
  assign mdu_req.d    = opd;
  assign mdu_req.mode = uc.mode;

  rie_mdu #(.FRACTION_BITS(FRACTION_BITS)) u_mdu (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mdu_start),
    .req   (mdu_req),
    .rsp   (mdu_rsp)
  );

  // Register file: one write port, two registered read ports
  always_ff @(posedge clk) begin
    if (wb_en) rf_mem[uc.dst] <= wb_data;
    rda_r <= rf_mem[uc.ra];
    rdb_r <= rf_mem[uc.rb];
  end

  // Sequencer, configuration and output register
  logic can_out;
  logic out_load;
  assign can_out  = !out_valid_r || !out_stall;
  assign out_load = can_out && !boot_r &&
                    (((st_r == S_EXEC) && (uc.op == OP_END)) || (st_r == S_DONE));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= S_FETCH;
      pc_r        <= PC_RESTART;
      boot_r      <= 1'b1;
      sat_r       <= 1'b0;
      out_valid_r <= 1'b0;
      period_r    <= PERIOD_RST;
      inertia_r   <= INERTIA_RST;
      cov_r       <= COV_RST;
      code_r      <= FORGET_RST;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_PERIOD:  period_r  <= cfg_wdata[19:0];
          CFG_INERTIA: inertia_r <= cfg_wdata[15:0];
          CFG_COV:     cov_r     <= cfg_wdata[15:0];
          CFG_FORGET:  code_r    <= cfg_wdata;
          default:     ;
        endcase
      end

      // output register: load a finished beat, else drain an accepted one
      if (out_load) begin
        out_valid_r <= 1'b1;
        out_data_r  <= '{inr_r, dmp_r, err_r, sat_r};
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end

      unique case (st_r)
        S_IDLE: begin
          if (in_valid) begin
            speed_r  <= in_data.speed_sample;
            torque_r <= in_data.torque_sample;
            sat_r    <= 1'b0;
            err_r    <= '0;
            inr_r    <= '0;
            dmp_r    <= '0;
            pc_r     <= in_data.kind ? PC_RESTART : PC_SAMPLE;
            st_r     <= S_FETCH;
          end
        end
        S_FETCH: st_r <= S_EXEC;
        S_EXEC: begin
          unique case (uc.op)
            OP_ADD, OP_SUB: begin
              sat_r <= sat_r | alu_sat;
              pc_r  <= pc_r + 6'd1;
              st_r  <= S_FETCH;
            end
            OP_MD: st_r <= S_WAIT;
            OP_END: begin
              if (boot_r) begin
                boot_r <= 1'b0;
                st_r   <= S_IDLE;
              end else if (can_out) begin
                st_r <= S_IDLE;
              end else begin
                st_r <= S_DONE;
              end
            end
            default: st_r <= S_IDLE;
          endcase
        end
        S_WAIT: begin
          if (mdu_rsp.done) begin
            sat_r <= sat_r | mdu_rsp.sat;
            pc_r  <= pc_r + 6'd1;
            st_r  <= S_FETCH;
          end
        end
        S_DONE: begin
          if (can_out) st_r <= S_IDLE;
        end
        default: st_r <= S_IDLE;
      endcase

      // result fields follow their register file writes
      if (wb_en && (uc.dst == R_ERR)) err_r <= wb_data;
      if (wb_en && (uc.dst == R_INR)) inr_r <= wb_data;
      if (wb_en && (uc.dst == R_DMP)) dmp_r <= wb_data;
    end
  end

  assign in_stall  = (st_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `RIE_ASSERT_IMP(a_done_in_wait, mdu_rsp.done, st_r == S_WAIT, "mdu done outside wait")
  `RIE_ASSERT_IMP(a_mdu_free, mdu_start, !mdu_rsp.busy, "mdu started while busy")
  `RIE_ASSERT_IMP(a_boot_busy, boot_r, st_r != S_IDLE, "idle before restart sequence ended")
  `RIE_ASSERT_IMP(a_out_from_end, $rose(out_valid_r),
    $past(st_r == S_EXEC) || $past(st_r == S_DONE), "output beat without sequence end")

endmodule
